>>> hw/rtl/wildcard_kmer_hit_counter_macros.svh
// ----------------------------------------------------------------------------
// Wildcard k-mer hit counter: assertion macros
// Shared concurrent assertion helpers, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef WILDCARD_KMER_HIT_COUNTER_MACROS_SVH
`define WILDCARD_KMER_HIT_COUNTER_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold in that cycle.
`define WKHC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define WKHC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/wkhc_pkg.sv
// ----------------------------------------------------------------------------
// Wildcard k-mer hit counter package
// Shared widths, register codes, payload types and the case-folding function.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wkhc_pkg;

  // Fixed field widths.
  localparam int CharW     = 8;
  localparam int PatChars  = 16;
  localparam int LenW      = 5;
  localparam int HitTotalW = 20;
  localparam int CfgDataW  = 64;
  localparam int CfgIdxW   = 2;

  // Parameter defaults.
  localparam int MaxPatternDef = 16;
  localparam int CountBitsDef  = 20;

  // Character constants.
  localparam logic [CharW-1:0] WildcardChar = 8'h2E;
  localparam logic [CharW-1:0] LowerA       = 8'h61;
  localparam logic [CharW-1:0] LowerZ       = 8'h7A;
  localparam logic [CharW-1:0] CaseOffset   = 8'h20;

  // Pattern length after reset.
  localparam logic [LenW-1:0] LenReset = 5'd1;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CfgPatLow  = 2'd0,
    CfgPatHigh = 2'd1,
    CfgPatLen  = 2'd2
  } cfg_reg_e;

  // Input transaction.
  typedef struct packed {
    logic [CharW-1:0] seq_char;
    logic             end_of_seq;
  } in_t;

  // Output transaction.
  typedef struct packed {
    logic                 window_hit;
    logic [HitTotalW-1:0] hit_total;
    logic                 final_result;
  } out_t;

  // Pattern as seen by the matcher: folded characters and clamped length.
  typedef struct packed {
    logic [PatChars-1:0][CharW-1:0] pat_chars;
    logic [LenW-1:0]                pat_len;
  } cfg_t;

  // Fold ASCII lower-case letters to upper case; other bytes pass unchanged.
  function automatic logic [CharW-1:0] fold_upper(input logic [CharW-1:0] c);
    if (c >= LowerA && c <= LowerZ) begin
      return c - CaseOffset;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/wildcard_kmer_hit_counter.sv
// ----------------------------------------------------------------------------
// Wildcard k-mer hit counter
// Counts wildcard pattern matches, case-insensitive, in a character stream.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid_i/in_ready_o  in_data_i  (seq_char, end_of_seq)
//   out      output     out_valid_o/out_ready_i out_data_o (window_hit, hit_total,
//                                                           final_result)
//   cfg      input      cfg_we_i               cfg_idx_i, cfg_wdata_i
//
// One character per clock sustained while the output is not stalled. An input
// transaction passes the input register, then the window compare and counter,
// whose result lands in the output register. A stalled output still lets one
// more character into the input register. Reset clears the window, fill, count
// and configuration (pattern length one); no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "wildcard_kmer_hit_counter_macros.svh"

module wildcard_kmer_hit_counter #(
  parameter int MaxPattern = wkhc_pkg::MaxPatternDef,
  parameter int CountBits  = wkhc_pkg::CountBitsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire wkhc_pkg::in_t                 in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output wkhc_pkg::out_t                     out_data_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [wkhc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [wkhc_pkg::CfgDataW-1:0] cfg_wdata_i
);

  wkhc_pkg::cfg_t cfg;
  wkhc_pkg::in_t  s1_q;
  logic           s1_valid_q;
  logic           adv;
  logic           hit;
  logic [wkhc_pkg::HitTotalW-1:0] total;

  wkhc_cfg_regs #(
    .MaxPattern (MaxPattern)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // The input register moves on when the output register is free or draining.
  assign adv        = s1_valid_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !s1_valid_q || adv;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_q <= in_data_i;
    end
  end

  wkhc_scan #(
    .MaxPattern (MaxPattern),
    .CountBits  (CountBits)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .char_i  (s1_q.seq_char),
    .last_i  (s1_q.end_of_seq),
    .cfg_i   (cfg),
    .hit_o   (hit),
    .total_o (total)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (adv) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_o.window_hit   <= hit;
      out_data_o.hit_total    <= total;
      out_data_o.final_result <= s1_q.end_of_seq;
    end
  end

  // A held input register with no room downstream must refuse new transactions.
  `WKHC_ASSERT_IMP(a_no_overrun, s1_valid_q && !adv, !in_ready_o, "input register overrun")

endmodule

`default_nettype wire

>>> hw/rtl/wkhc_cfg_regs.sv
// ----------------------------------------------------------------------------
// Wildcard k-mer hit counter configuration registers
// Holds the pattern words and length; presents folded characters and the
// clamped pattern length to the matcher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wkhc_cfg_regs #(
  parameter int MaxPattern = wkhc_pkg::MaxPatternDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [wkhc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [wkhc_pkg::CfgDataW-1:0] cfg_wdata_i,
  output wkhc_pkg::cfg_t                     cfg_o
);

  localparam int Lim  = (MaxPattern < wkhc_pkg::PatChars) ? MaxPattern : wkhc_pkg::PatChars;
  localparam int LenW = wkhc_pkg::LenW;

  logic [wkhc_pkg::CfgDataW-1:0] pat_low_q, pat_high_q;
  logic [LenW-1:0]               len_q;

  // Register writes; an index past the list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      len_q      <= wkhc_pkg::LenReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        wkhc_pkg::CfgPatLow:  pat_low_q  <= cfg_wdata_i;
        wkhc_pkg::CfgPatHigh: pat_high_q <= cfg_wdata_i;
        wkhc_pkg::CfgPatLen:  len_q      <= cfg_wdata_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  // Fold the pattern characters and clamp the length to one..Lim.
  always_comb begin
    logic [2*wkhc_pkg::CfgDataW-1:0] pat_all;
    pat_all = {pat_high_q, pat_low_q};
    for (int i = 0; i < wkhc_pkg::PatChars; i++) begin
      cfg_o.pat_chars[i] = wkhc_pkg::fold_upper(pat_all[i*wkhc_pkg::CharW +: wkhc_pkg::CharW]);
    end
    if (len_q == '0) begin
      cfg_o.pat_len = LenW'(1);
    end else if (int'(len_q) > Lim) begin
      cfg_o.pat_len = LenW'(Lim);
    end else begin
      cfg_o.pat_len = len_q;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/wkhc_scan.sv
// ----------------------------------------------------------------------------
// Wildcard k-mer hit counter scan unit
// Character window, sequence fill and hit counter, with the parallel
// wildcard compare of the window that ends at the incoming character.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "wildcard_kmer_hit_counter_macros.svh"

module wkhc_scan #(
  parameter int MaxPattern = wkhc_pkg::MaxPatternDef,
  parameter int CountBits  = wkhc_pkg::CountBitsDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           adv_i,
  input  wire logic [wkhc_pkg::CharW-1:0]     char_i,
  input  wire logic                           last_i,
  input  wire wkhc_pkg::cfg_t                 cfg_i,
  output logic                                hit_o,
  output logic [wkhc_pkg::HitTotalW-1:0]      total_o
);

  localparam int Lim     = (MaxPattern < wkhc_pkg::PatChars) ? MaxPattern : wkhc_pkg::PatChars;
  localparam int IdxW    = (Lim > 1) ? $clog2(Lim) : 1;
  localparam int NwDepth = 2 ** IdxW;
  localparam int FillW   = $clog2(Lim + 1);
  localparam int CharW   = wkhc_pkg::CharW;
  localparam int LenW    = wkhc_pkg::LenW;
  localparam int HitW    = wkhc_pkg::HitTotalW;

  logic [CharW-1:0]     win_q [Lim];
  logic [CharW-1:0]     nw    [NwDepth];
  logic [CharW-1:0]     char_f;
  logic [FillW-1:0]     fill_q, fill_inc;
  logic [CountBits-1:0] cnt_q, cnt_inc;
  logic                 all_ok;

  assign char_f = wkhc_pkg::fold_upper(char_i);

  // Window as it stands once this character has been shifted in.
  always_comb begin
    for (int k = 0; k < NwDepth; k++) begin
      nw[k] = '0;
    end
    nw[0] = char_f;
    for (int k = 1; k < Lim; k++) begin
      nw[k] = win_q[k-1];
    end
  end

  // Fill counts characters of this sequence, saturating at the window size.
  assign fill_inc = (fill_q == FillW'(Lim)) ? fill_q : fill_q + FillW'(1);

  // Pattern character i lines up with window position len-1-i.
  always_comb begin
    all_ok = 1'b1;
    for (int i = 0; i < Lim; i++) begin
      logic [LenW-1:0]  pos;
      logic [CharW-1:0] s_char;
      logic [CharW-1:0] p_char;
      pos    = cfg_i.pat_len - LenW'(1) - LenW'(i);
      s_char = nw[pos[IdxW-1:0]];
      p_char = cfg_i.pat_chars[i];
      if (LenW'(i) < cfg_i.pat_len && p_char != wkhc_pkg::WildcardChar && p_char != s_char) begin
        all_ok = 1'b0;
      end
    end
  end

  assign hit_o   = all_ok && (int'(fill_inc) >= int'(cfg_i.pat_len));
  assign cnt_inc = (hit_o && cnt_q != '1) ? cnt_q + CountBits'(1) : cnt_q;
  assign total_o = HitW'(cnt_inc);

  // State update on each character taken into the scan.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < Lim; k++) begin
        win_q[k] <= '0;
      end
      fill_q <= '0;
      cnt_q  <= '0;
    end else if (adv_i) begin
      for (int k = Lim - 1; k > 0; k--) begin
        win_q[k] <= win_q[k-1];
      end
      win_q[0] <= char_f;
      fill_q   <= last_i ? '0 : fill_inc;
      cnt_q    <= last_i ? '0 : cnt_inc;
    end
  end

  // A sequence end leaves fill and count cleared.
  `WKHC_ASSERT_NXT(a_seq_end_clears, adv_i && last_i, fill_q == '0 && cnt_q == '0, "sequence end did not clear state")
  // Within a sequence the count moves by at most one.
  `WKHC_ASSERT_NXT(a_cnt_step, adv_i && !last_i, cnt_q == $past(cnt_q) || cnt_q == $past(cnt_q) + CountBits'(1), "count stepped by more than one")
  // Without a character the scan state holds.
  `WKHC_ASSERT_NXT(a_idle_hold, !adv_i, $stable(cnt_q) && $stable(fill_q), "scan state changed while idle")

endmodule

`default_nettype wire
